[rtl/core/follower_zone_classifier_assert.svh]
// assertion macros shared by the classifier rtl
`ifndef FOLLOWER_ZONE_CLASSIFIER_ASSERT_SVH
`define FOLLOWER_ZONE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH
`define FZC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fzc assertion failed");
`define FZC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fzc assertion failed");
`else
`define FZC_ASSERT(label, clk, rst, prop)
`define FZC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/fzc_pkg.sv]
package fzc_pkg;

  localparam int VERTEX_BITS    = 24;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COUNT_BITS     = 3;
  localparam int THRESH_BITS    = 20;
  localparam int STATE_BITS     = 2;
  localparam int NEAR_BITS      = 10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_FIRST   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_THRESHOLD = 3'd7;

  localparam logic [COUNT_BITS-1:0]  COUNT_MIN         = 3'd3;
  localparam logic [COUNT_BITS-1:0]  COUNT_RESET       = 3'd3;
  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET   = 20'd268;

  localparam logic [STATE_BITS-1:0] ST_FOLLOWING     = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_NOT_FOLLOWING = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_STOPPED       = 2'd2;
  localparam logic [STATE_BITS-1:0] ST_UNKNOWN       = 2'd3;

  typedef struct packed {
    logic accept;
    logic load2;
    logic load3;
  } pipe_ctl_t;

endpackage

[rtl/core/fzc_in_if.sv]
interface fzc_in_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic                         track_present;
  logic signed [COORD_BITS-1:0] person_x;
  logic signed [COORD_BITS-1:0] person_y;
  logic signed [COORD_BITS-1:0] robot_x;
  logic signed [COORD_BITS-1:0] robot_y;

  modport source (
    output valid, track_present, person_x, person_y, robot_x, robot_y,
    input  ready
  );

  modport sink (
    input  valid, track_present, person_x, person_y, robot_x, robot_y,
    output ready
  );
endinterface

[rtl/core/fzc_out_if.sv]
interface fzc_out_if ();
  import fzc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATE_BITS-1:0] zone_state;

  modport source (
    output valid, zone_state,
    input  ready
  );

  modport sink (
    input  valid, zone_state,
    output ready
  );
endinterface

[rtl/core/fzc_cfg_regs.sv]
module fzc_cfg_regs #(
  parameter int MAX_VERTICES = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fzc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fzc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [fzc_pkg::CFG_DATA_BITS-1:0]    vertex [MAX_VERTICES],
  output logic [fzc_pkg::COUNT_BITS-1:0]       vertex_count,
  output logic [fzc_pkg::THRESH_BITS-1:0]      stop_threshold_sq
);
  import fzc_pkg::*;

  logic [COUNT_BITS-1:0] count_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_raw         <= COUNT_RESET;
      stop_threshold_sq <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT:   count_raw <= cfg_data[COUNT_BITS-1:0];
        REG_STOP_THRESHOLD: stop_threshold_sq <= cfg_data[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_vertex
    always_ff @(posedge clk) begin
      if (rst) begin
        vertex[i] <= '0;
      end else if (cfg_we && cfg_index == REG_VERTEX_FIRST + CFG_INDEX_BITS'(i)) begin
        vertex[i] <= cfg_data;
      end
    end
  end

  // counts outside the usable range snap to the nearest end
  always_comb begin
    if (count_raw < COUNT_MIN) begin
      vertex_count = COUNT_MIN;
    end else if (count_raw > COUNT_BITS'(MAX_VERTICES)) begin
      vertex_count = COUNT_BITS'(MAX_VERTICES);
    end else begin
      vertex_count = count_raw;
    end
  end

endmodule

[rtl/core/fzc_motion.sv]
module fzc_motion #(
  parameter int COORD_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fzc_pkg::pipe_ctl_t                 ctl,
  input  logic                               track_present,
  input  logic signed [COORD_BITS-1:0]       person_x,
  input  logic signed [COORD_BITS-1:0]       person_y,
  input  logic [fzc_pkg::THRESH_BITS-1:0]    stop_threshold_sq,
  output logic                               stopped
);
  import fzc_pkg::*;

  localparam int DB = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  logic signed [DB-1:0]         dx;
  logic signed [DB-1:0]         dy;
  logic [DB-1:0]                mag_x;
  logic [DB-1:0]                mag_y;
  logic [2*NEAR_BITS-1:0]       sq_x;
  logic [2*NEAR_BITS-1:0]       sq_y;
  logic [2*NEAR_BITS:0]         sq_sum;
  logic                         near;
  logic                         stopped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (ctl.accept && track_present) begin
      last_x <= person_x;
      last_y <= person_y;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      dx <= DB'(person_x) - DB'(last_x);
      dy <= DB'(person_y) - DB'(last_y);
    end
  end

  // any component of 1024 or more can never fall below the threshold
  always_comb begin
    mag_x        = dx[DB-1] ? DB'(-dx) : DB'(dx);
    mag_y        = dy[DB-1] ? DB'(-dy) : DB'(dy);
    near         = (mag_x < DB'(2 ** NEAR_BITS)) && (mag_y < DB'(2 ** NEAR_BITS));
    sq_x         = mag_x[NEAR_BITS-1:0] * mag_x[NEAR_BITS-1:0];
    sq_y         = mag_y[NEAR_BITS-1:0] * mag_y[NEAR_BITS-1:0];
    sq_sum       = {1'b0, sq_x} + {1'b0, sq_y};
    stopped_next = near && (sq_sum < (2*NEAR_BITS+1)'(stop_threshold_sq));
  end

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      stopped <= stopped_next;
    end
  end

`include "follower_zone_classifier_assert.svh"

  `FZC_ASSERT(a_untracked_keeps_last, clk, rst,
    (ctl.accept && !track_present) |=> ($stable(last_x) && $stable(last_y)))

endmodule

[rtl/core/fzc_edge_pipe.sv]
module fzc_edge_pipe #(
  parameter int MAX_VERTICES = 6,
  parameter int COORD_BITS   = 24
) (
  input  logic                                clk,
  input  fzc_pkg::pipe_ctl_t                  ctl,
  input  logic signed [COORD_BITS:0]          rel_x,
  input  logic signed [COORD_BITS:0]          rel_y,
  input  logic [fzc_pkg::CFG_DATA_BITS-1:0]   vertex [MAX_VERTICES],
  input  logic [fzc_pkg::COUNT_BITS-1:0]      vertex_count,
  output logic                                zone_hit
);
  import fzc_pkg::*;

  localparam int RW = COORD_BITS + 1;
  localparam int DW = ((RW > VERTEX_BITS) ? RW : VERTEX_BITS) + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax [MAX_VERTICES];
  logic signed [DW-1:0] ay [MAX_VERTICES];
  logic signed [DW-1:0] bx [MAX_VERTICES];
  logic signed [DW-1:0] by [MAX_VERTICES];
  logic signed [PW-1:0] cross_l [MAX_VERTICES];
  logic signed [PW-1:0] cross_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] active2;
  logic [MAX_VERTICES-1:0] active3;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_edge
    localparam int NXT = (i + 1) % MAX_VERTICES;

    logic [CFG_DATA_BITS-1:0] far_vertex;
    logic signed [DW-1:0]     rx_e;
    logic signed [DW-1:0]     ry_e;

    // the last edge in use closes back onto vertex zero
    assign far_vertex = (vertex_count == COUNT_BITS'(i + 1)) ? vertex[0] : vertex[NXT];
    assign rx_e       = DW'(rel_x);
    assign ry_e       = DW'(rel_y);

    always_ff @(posedge clk) begin
      if (ctl.load2) begin
        ax[i]      <= DW'($signed(vertex[i][VERTEX_BITS-1:0])) - rx_e;
        ay[i]      <= DW'($signed(vertex[i][2*VERTEX_BITS-1:VERTEX_BITS])) - ry_e;
        bx[i]      <= DW'($signed(far_vertex[VERTEX_BITS-1:0])) - rx_e;
        by[i]      <= DW'($signed(far_vertex[2*VERTEX_BITS-1:VERTEX_BITS])) - ry_e;
        active2[i] <= COUNT_BITS'(i) < vertex_count;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load3) begin
        cross_l[i] <= PW'(ax[i]) * PW'(by[i]);
        cross_r[i] <= PW'(bx[i]) * PW'(ay[i]);
        active3[i] <= active2[i];
      end
    end
  end

  // on an edge counts as inside, so only a strictly negative cross product fails
  always_comb begin
    zone_hit = 1'b1;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (active3[i] && (cross_l[i] < cross_r[i])) begin
        zone_hit = 1'b0;
      end
    end
  end

endmodule

[rtl/core/follower_zone_classifier.sv]
// Follower zone classifier: each input transaction carries a track flag, the
// person's position and the robot's position (signed Q10.14 metres) and
// yields one zone state: unknown without a track, stopped when the person
// has moved less than the configured squared distance since the last tracked
// position, otherwise following or not following depending on whether the
// person, taken relative to the robot, lies in the counter-clockwise convex
// polygon set by the vertex registers (a point on an edge counts as inside).
// The block takes one transaction per clock cycle unless the output stalls; a
// result passes the input register, the difference register, the per-edge
// cross-product multiplier register and the result register. Configuration is to be
// written by the user only while the block is idle; the block does not enforce it.
module follower_zone_classifier #(
  parameter int MAX_VERTICES = 6,
  parameter int COORD_BITS   = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  fzc_in_if.sink                             items,
  fzc_out_if.source                          results,
  input  logic                               cfg_we,
  input  logic [fzc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fzc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fzc_pkg::*;

  logic [CFG_DATA_BITS-1:0] vertex [MAX_VERTICES];
  logic [COUNT_BITS-1:0]    vertex_count;
  logic [THRESH_BITS-1:0]   stop_threshold_sq;

  pipe_ctl_t ctl;
  logic      en2;
  logic      en3;
  logic      en4;

  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic                   out_valid;
  logic                   trk1;
  logic                   trk2;
  logic                   trk3;
  logic                   stop2;
  logic                   stop3;
  logic                   zone_hit;
  logic signed [COORD_BITS:0] rel_x;
  logic signed [COORD_BITS:0] rel_y;
  logic [STATE_BITS-1:0]  state;
  logic [STATE_BITS-1:0]  state_next;

  // each stage moves on when the one after it is empty or moving
  assign en4         = !out_valid || results.ready;
  assign en3         = !v3 || en4;
  assign en2         = !v2 || en3;
  assign items.ready = !v1 || en2;

  assign ctl.accept = items.valid && items.ready;
  assign ctl.load2  = en2;
  assign ctl.load3  = en3;

  fzc_cfg_regs #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .vertex            (vertex),
    .vertex_count      (vertex_count),
    .stop_threshold_sq (stop_threshold_sq)
  );

  fzc_motion #(
    .COORD_BITS (COORD_BITS)
  ) u_motion (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .track_present     (items.track_present),
    .person_x          (items.person_x),
    .person_y          (items.person_y),
    .stop_threshold_sq (stop_threshold_sq),
    .stopped           (stop2)
  );

  fzc_edge_pipe #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_edges (
    .clk          (clk),
    .ctl          (ctl),
    .rel_x        (rel_x),
    .rel_y        (rel_y),
    .vertex       (vertex),
    .vertex_count (vertex_count),
    .zone_hit     (zone_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (items.ready) v1 <= items.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready) begin
      trk1  <= items.track_present;
      rel_x <= (COORD_BITS+1)'(items.person_x) - (COORD_BITS+1)'(items.robot_x);
      rel_y <= (COORD_BITS+1)'(items.person_y) - (COORD_BITS+1)'(items.robot_y);
    end
    if (en2) begin
      trk2 <= trk1;
    end
    if (en3) begin
      trk3  <= trk2;
      stop3 <= stop2;
    end
    if (en4) begin
      state <= state_next;
    end
  end

  always_comb begin
    if (!trk3) begin
      state_next = ST_UNKNOWN;
    end else if (stop3) begin
      state_next = ST_STOPPED;
    end else if (zone_hit) begin
      state_next = ST_FOLLOWING;
    end else begin
      state_next = ST_NOT_FOLLOWING;
    end
  end

  assign results.valid      = out_valid;
  assign results.zone_state = state;

`include "follower_zone_classifier_assert.svh"

  `FZC_ASSERT(a_accept_fills_stage1, clk, rst,
    (items.valid && items.ready) |=> v1)
  `FZC_ASSERT(a_no_track_unknown, clk, rst,
    (en4 && v3 && !trk3) |=> (results.zone_state == ST_UNKNOWN))
  `FZC_ASSERT(a_stop_wins, clk, rst,
    (en4 && v3 && trk3 && stop3) |=> (results.zone_state == ST_STOPPED))

endmodule
